FILE: design/dice_sum_count_matrix_power_assert.svh
// Assertion macros for the dice sum counter checker.
// Used by dsc_checker.sv; no other dependencies.
`ifndef DICE_SUM_COUNT_MATRIX_POWER_ASSERT_SVH
`define DICE_SUM_COUNT_MATRIX_POWER_ASSERT_SVH

// same-cycle implication
`define DSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsc assertion failed");

// next-cycle implication
`define DSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsc assertion failed");

`endif

FILE: design/dsc_pkg.sv
// Shared constants, types and datapath command word for the dice sum counter.
// No dependencies.
package dsc_pkg;

   localparam int FACES_DEF     = 6;
   localparam int SUM_WIDTH_DEF = 63;
   localparam int MAX_FACES     = 16;
   localparam int IDX_W         = $clog2(MAX_FACES);
   localparam int RES_W         = 30;
   localparam int PROD_W        = 2 * RES_W;
   localparam int MU_W          = RES_W + 1;
   localparam int RED_W         = RES_W + 2;
   localparam int DRAIN_W       = 3;
   localparam logic [DRAIN_W-1:0] DRAIN_CYC = 3'd7;

   localparam logic [RES_W-1:0] PRIME = 30'd1000000007;
   localparam logic [63:0] MU_FULL = (64'd1 << PROD_W) / 64'd1000000007;
   localparam logic [MU_W-1:0] BAR_MU = MU_FULL[MU_W-1:0];

   typedef enum logic [1:0] {
      RGN_A,
      RGN_B,
      RGN_T
   } mat_rgn_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_A,
      ST_INIT_B,
      ST_STEP,
      ST_MUL,
      ST_MUL_WAIT,
      ST_COPY,
      ST_COPY_WAIT,
      ST_DOT,
      ST_DOT_WAIT,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic              init_we;
      logic              init_data;
      logic              mac_go;
      logic              cpy_go;
      mat_rgn_type       x_rgn;
      logic [IDX_W-1:0]  x_row;
      logic [IDX_W-1:0]  x_col;
      mat_rgn_type       y_rgn;
      logic [IDX_W-1:0]  y_row;
      logic [IDX_W-1:0]  y_col;
      mat_rgn_type       d_rgn;
      logic [IDX_W-1:0]  d_row;
      logic [IDX_W-1:0]  d_col;
      logic              use_seed;
      logic [RES_W-1:0]  seed;
      logic              first;
      logic              last;
      logic              to_out;
      logic              small_ld;
      logic [RES_W-1:0]  small_val;
      logic              out_ld;
   } dp_cmd_type;

endpackage

FILE: design/dsc_if.sv
// Valid/ready channel interfaces for the dice sum counter request and response.
// Uses dsc_pkg for default widths.
interface dsc_req_if #(
   parameter int SUM_WIDTH = dsc_pkg::SUM_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic [SUM_WIDTH-1:0] target_sum;

   modport source (output valid, output target_sum, input ready);
   modport sink   (input valid, input target_sum, output ready);
endinterface

interface dsc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dsc_pkg::RES_W-1:0]   way_count;

   modport source (output valid, output way_count, input ready);
   modport sink   (input valid, input way_count, output ready);
endinterface

FILE: design/dsc_ctl.sv
// Controller: sequences init, matrix multiply, copy and final dot product sweeps.
// Uses dsc_pkg; drives the datapath command word.
module dsc_ctl #(
   parameter int FACES     = dsc_pkg::FACES_DEF,
   parameter int SUM_WIDTH = dsc_pkg::SUM_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SUM_WIDTH-1:0]  target_sum,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dsc_pkg::dp_cmd_type   cmd
);

   localparam int IW = $clog2(FACES);
   localparam logic [IW-1:0] FM1 = IW'(FACES - 1);

   dsc_pkg::ctl_state_type st_ff, st_in;
   logic [SUM_WIDTH-1:0]         e_ff, e_in;
   logic                         sq_ff, sq_in;
   logic [IW-1:0]                r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [dsc_pkg::DRAIN_W-1:0]  dr_ff, dr_in;
   logic                         rv_ff, rv_in;
   logic                         accept, short_sum, out_ld;
   logic                         c_last, r_last, k_last, dr_done;
   logic [IW:0]                  n_lo;

   assign req_ready = (st_ff == dsc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rv_ff;
   assign short_sum = target_sum <= SUM_WIDTH'(FACES);
   assign n_lo      = target_sum[IW:0];
   assign c_last    = (c_ff == FM1);
   assign r_last    = (r_ff == FM1);
   assign k_last    = (k_ff == FM1);
   assign dr_done   = (dr_ff == dsc_pkg::DRAIN_CYC);
   assign out_ld    = (st_ff == dsc_pkg::ST_DONE) && (!rv_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= dsc_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         e_ff  <= '0;
         sq_ff <= 1'b0;
         r_ff  <= '0;
         c_ff  <= '0;
         k_ff  <= '0;
         dr_ff <= '0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         e_ff  <= e_in;
         sq_ff <= sq_in;
         r_ff  <= r_in;
         c_ff  <= c_in;
         k_ff  <= k_in;
         dr_ff <= dr_in;
      end
   end

   // next state and sweep counters
   always_comb begin
      st_in = st_ff;
      e_in  = e_ff;
      sq_in = sq_ff;
      r_in  = r_ff;
      c_in  = c_ff;
      k_in  = k_ff;
      dr_in = '0;
      rv_in = out_ld ? 1'b1 : (rv_ff && !rsp_ready);
      unique case (st_ff)
         dsc_pkg::ST_IDLE: begin
            r_in = '0;
            c_in = '0;
            k_in = '0;
            if (accept) begin
               if (short_sum) begin
                  st_in = dsc_pkg::ST_DONE;
               end else begin
                  e_in  = target_sum - SUM_WIDTH'(FACES);
                  st_in = dsc_pkg::ST_INIT_A;
               end
            end
         end
         dsc_pkg::ST_INIT_A, dsc_pkg::ST_INIT_B, dsc_pkg::ST_COPY: begin
            c_in = c_last ? '0 : c_ff + 1'b1;
            if (c_last) begin
               r_in = r_last ? '0 : r_ff + 1'b1;
               if (r_last) begin
                  priority case (st_ff)
                     dsc_pkg::ST_INIT_A: st_in = dsc_pkg::ST_INIT_B;
                     dsc_pkg::ST_INIT_B: st_in = dsc_pkg::ST_STEP;
                     default:            st_in = dsc_pkg::ST_COPY_WAIT;
                  endcase
               end
            end
         end
         dsc_pkg::ST_STEP: begin
            sq_in = !e_ff[0];
            st_in = dsc_pkg::ST_MUL;
         end
         dsc_pkg::ST_MUL: begin
            k_in = k_last ? '0 : k_ff + 1'b1;
            if (k_last) begin
               c_in = c_last ? '0 : c_ff + 1'b1;
               if (c_last) begin
                  r_in = r_last ? '0 : r_ff + 1'b1;
                  if (r_last) begin
                     st_in = dsc_pkg::ST_MUL_WAIT;
                  end
               end
            end
         end
         dsc_pkg::ST_MUL_WAIT: begin
            dr_in = dr_ff + 1'b1;
            if (dr_done) begin
               dr_in = '0;
               st_in = dsc_pkg::ST_COPY;
            end
         end
         dsc_pkg::ST_COPY_WAIT: begin
            dr_in = dr_ff + 1'b1;
            if (dr_done) begin
               dr_in = '0;
               if (sq_ff) begin
                  e_in  = e_ff >> 1;
                  st_in = dsc_pkg::ST_STEP;
               end else if (e_ff[SUM_WIDTH-1:1] == '0) begin
                  st_in = dsc_pkg::ST_DOT;
               end else begin
                  sq_in = 1'b1;
                  st_in = dsc_pkg::ST_MUL;
               end
            end
         end
         dsc_pkg::ST_DOT: begin
            c_in = c_last ? '0 : c_ff + 1'b1;
            if (c_last) begin
               st_in = dsc_pkg::ST_DOT_WAIT;
            end
         end
         dsc_pkg::ST_DOT_WAIT: begin
            dr_in = dr_ff + 1'b1;
            if (dr_done) begin
               dr_in = '0;
               st_in = dsc_pkg::ST_DONE;
            end
         end
         dsc_pkg::ST_DONE: begin
            if (out_ld) begin
               st_in = dsc_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = dsc_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd        = '0;
      cmd.x_rgn  = dsc_pkg::RGN_A;
      cmd.y_rgn  = dsc_pkg::RGN_B;
      cmd.d_rgn  = dsc_pkg::RGN_T;
      cmd.out_ld = out_ld;
      unique case (st_ff)
         dsc_pkg::ST_IDLE: begin
            cmd.small_ld  = accept && short_sum;
            cmd.small_val = (n_lo == '0) ? '0 :
                            (dsc_pkg::RES_W'(1) << (n_lo - (IW + 1)'(1)));
         end
         dsc_pkg::ST_INIT_A: begin
            cmd.init_we   = 1'b1;
            cmd.d_rgn     = dsc_pkg::RGN_A;
            cmd.d_row     = dsc_pkg::IDX_W'(r_ff);
            cmd.d_col     = dsc_pkg::IDX_W'(c_ff);
            cmd.init_data = (r_ff == c_ff);
         end
         dsc_pkg::ST_INIT_B: begin
            cmd.init_we   = 1'b1;
            cmd.d_rgn     = dsc_pkg::RGN_B;
            cmd.d_row     = dsc_pkg::IDX_W'(r_ff);
            cmd.d_col     = dsc_pkg::IDX_W'(c_ff);
            cmd.init_data = (r_ff == '0) || (c_ff == r_ff - 1'b1);
         end
         dsc_pkg::ST_MUL: begin
            cmd.mac_go = 1'b1;
            cmd.x_rgn  = sq_ff ? dsc_pkg::RGN_B : dsc_pkg::RGN_A;
            cmd.x_row  = dsc_pkg::IDX_W'(r_ff);
            cmd.x_col  = dsc_pkg::IDX_W'(k_ff);
            cmd.y_row  = dsc_pkg::IDX_W'(k_ff);
            cmd.y_col  = dsc_pkg::IDX_W'(c_ff);
            cmd.d_row  = dsc_pkg::IDX_W'(r_ff);
            cmd.d_col  = dsc_pkg::IDX_W'(c_ff);
            cmd.first  = (k_ff == '0);
            cmd.last   = k_last;
         end
         dsc_pkg::ST_COPY: begin
            cmd.cpy_go = 1'b1;
            cmd.x_rgn  = dsc_pkg::RGN_T;
            cmd.x_row  = dsc_pkg::IDX_W'(r_ff);
            cmd.x_col  = dsc_pkg::IDX_W'(c_ff);
            cmd.d_rgn  = sq_ff ? dsc_pkg::RGN_B : dsc_pkg::RGN_A;
            cmd.d_row  = dsc_pkg::IDX_W'(r_ff);
            cmd.d_col  = dsc_pkg::IDX_W'(c_ff);
         end
         dsc_pkg::ST_DOT: begin
            cmd.mac_go   = 1'b1;
            cmd.x_col    = dsc_pkg::IDX_W'(c_ff);
            cmd.use_seed = 1'b1;
            cmd.seed     = dsc_pkg::RES_W'(1) << (FM1 - c_ff);
            cmd.first    = (c_ff == '0);
            cmd.last     = c_last;
            cmd.to_out   = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: design/dsc_dp.sv
// Datapath: matrix store (A, B, scratch), pipelined Barrett modular multiply-add.
// Uses dsc_pkg; driven by the dsc_ctl command word.
module dsc_dp #(
   parameter int FACES = dsc_pkg::FACES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dsc_pkg::dp_cmd_type         cmd,
   output logic [dsc_pkg::RES_W-1:0]   way_count
);

   localparam int IW = $clog2(FACES);
   localparam int AW = 2 + 2 * IW;
   localparam int RW = dsc_pkg::RES_W;

   logic [RW-1:0] mem [2**AW];

   dsc_pkg::dp_cmd_type cmd1_ff, cmd2_ff, cmd3_ff, cmd4_ff, cmd5_ff, cmd6_ff;

   logic [AW-1:0]                 xa, ya, wa;
   logic [RW-1:0]                 wd;
   logic                          we;
   logic [RW-1:0]                 rx_ff, ry_ff, op_y;
   logic [dsc_pkg::PROD_W-1:0]    prod_ff;
   logic [2*dsc_pkg::MU_W-1:0]    q2_ff;
   logic [dsc_pkg::RED_W-1:0]     prod3_ff, prod4_ff, qp_ff, diff;
   logic [dsc_pkg::MU_W-1:0]      q3;
   logic [RW-1:0]                 red_ff, red_in, acc_ff, res_ff, way_ff;
   logic [RW:0]                   sum;

   assign xa = {cmd.x_rgn, cmd.x_row[IW-1:0], cmd.x_col[IW-1:0]};
   assign ya = {cmd.y_rgn, cmd.y_row[IW-1:0], cmd.y_col[IW-1:0]};

   // write port: init sweep, then copy, then multiply results
   always_comb begin
      we = 1'b0;
      wa = {cmd.d_rgn, cmd.d_row[IW-1:0], cmd.d_col[IW-1:0]};
      wd = RW'(cmd.init_data);
      priority if (cmd.init_we) begin
         we = 1'b1;
      end else if (cmd1_ff.cpy_go) begin
         we = 1'b1;
         wa = {cmd1_ff.d_rgn, cmd1_ff.d_row[IW-1:0], cmd1_ff.d_col[IW-1:0]};
         wd = rx_ff;
      end else if (cmd6_ff.mac_go && cmd6_ff.last && !cmd6_ff.to_out) begin
         we = 1'b1;
         wa = {cmd6_ff.d_rgn, cmd6_ff.d_row[IW-1:0], cmd6_ff.d_col[IW-1:0]};
         wd = acc_ff;
      end else begin
         we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rx_ff <= mem[xa];
      ry_ff <= mem[ya];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd1_ff <= '0;
         cmd2_ff <= '0;
         cmd3_ff <= '0;
         cmd4_ff <= '0;
         cmd5_ff <= '0;
         cmd6_ff <= '0;
      end else begin
         cmd1_ff <= cmd;
         cmd2_ff <= cmd1_ff;
         cmd3_ff <= cmd2_ff;
         cmd4_ff <= cmd3_ff;
         cmd5_ff <= cmd4_ff;
         cmd6_ff <= cmd5_ff;
      end
   end

   assign op_y = cmd1_ff.use_seed ? cmd1_ff.seed : ry_ff;
   assign q3   = q2_ff[2*dsc_pkg::MU_W-1:dsc_pkg::MU_W];
   assign diff = prod4_ff - qp_ff;

   always_comb begin
      priority if (diff >= {1'b0, dsc_pkg::PRIME, 1'b0}) begin
         red_in = RW'(diff - {1'b0, dsc_pkg::PRIME, 1'b0});
      end else if (diff >= {2'b00, dsc_pkg::PRIME}) begin
         red_in = RW'(diff - {2'b00, dsc_pkg::PRIME});
      end else begin
         red_in = RW'(diff);
      end
   end

   assign sum = (cmd5_ff.first ? '0 : {1'b0, acc_ff}) + {1'b0, red_ff};

   // multiply, Barrett quotient estimate, subtract, correct, accumulate
   always_ff @(posedge clock) begin
      prod_ff  <= dsc_pkg::PROD_W'(rx_ff) * dsc_pkg::PROD_W'(op_y);
      q2_ff    <= (2*dsc_pkg::MU_W)'(prod_ff[dsc_pkg::PROD_W-1:RW-1]) *
                  (2*dsc_pkg::MU_W)'(dsc_pkg::BAR_MU);
      prod3_ff <= prod_ff[dsc_pkg::RED_W-1:0];
      qp_ff    <= dsc_pkg::RED_W'(q3) * dsc_pkg::RED_W'(dsc_pkg::PRIME);
      prod4_ff <= prod3_ff;
      red_ff   <= red_in;
      if (cmd5_ff.mac_go) begin
         acc_ff <= (sum >= {1'b0, dsc_pkg::PRIME}) ? RW'(sum - {1'b0, dsc_pkg::PRIME})
                                                   : RW'(sum);
      end
      if (cmd.small_ld) begin
         res_ff <= cmd.small_val;
      end else if (cmd6_ff.mac_go && cmd6_ff.last && cmd6_ff.to_out) begin
         res_ff <= acc_ff;
      end
      if (cmd.out_ld) begin
         way_ff <= res_ff;
      end
   end

   assign way_count = way_ff;

endmodule

FILE: design/dice_sum_count_matrix_power.sv
// Dice sum counter: number of ordered rolls of faces 1..FACES summing to n, mod 1000000007.
// Takes one request at a time. Sums 0..FACES load the result register when the request
// is taken, then move to the output register once the response slot is free. Larger sums
// build A = I and B = companion matrix, then for each bit of n-FACES pass the step state
// and run matrix products on one pipelined Barrett multiply-add unit fed by a
// two-read-port matrix store, then a dot product and a drain.
module dice_sum_count_matrix_power #(
   parameter int FACES     = dsc_pkg::FACES_DEF,
   parameter int SUM_WIDTH = dsc_pkg::SUM_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dsc_req_if.sink    req_ch,
   dsc_rsp_if.source  rsp_ch
);

   dsc_pkg::dp_cmd_type cmd;

   dsc_ctl #(
      .FACES     (FACES),
      .SUM_WIDTH (SUM_WIDTH)
   ) u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .target_sum (req_ch.target_sum),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd)
   );

   dsc_dp #(
      .FACES (FACES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .way_count (rsp_ch.way_count)
   );

endmodule

FILE: design/dsc_checker.sv
// Port-level checker for the dice sum counter, bound to the top level.
// Uses the assertion macros of dice_sum_count_matrix_power_assert.svh.
`include "dice_sum_count_matrix_power_assert.svh"

module dsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [29:0] way_count
);

   `DSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `DSC_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(way_count))
   `DSC_ASSERT_IMP(a_rsp_range, clock, reset, rsp_valid, way_count < 30'd1000000007)
   `DSC_ASSERT_NXT(a_one_word, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind dice_sum_count_matrix_power dsc_checker u_dsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .way_count (rsp_ch.way_count)
);

FILE: tb/sv/tb_top.sv
// Testbench for the dice sum counter: drives target sums and checks every way count.
// Depends on dsc_pkg, the dsc_req_if/dsc_rsp_if interfaces and the block itself.
class way_count_board;
   bit [dsc_pkg::RES_W-1:0] pending[$];
   int errors;

   function longint unsigned mulmod(longint unsigned a, longint unsigned b);
      return (a * b) % 64'd1000000007;
   endfunction

   function bit [dsc_pkg::RES_W-1:0] count_rolls(longint unsigned n);
      longint unsigned step[6][6];
      longint unsigned power[6][6];
      longint unsigned prod[6][6];
      longint unsigned acc;
      longint unsigned rem;
      if (n == 0) return '0;
      if (n <= 6) return 30'(64'd1 << (n - 1));
      foreach (step[r, c]) begin
         step[r][c] = (r == 0 || r == c + 1) ? 1 : 0;
         power[r][c] = (r == c) ? 1 : 0;
      end
      rem = n - 6;
      while (rem > 0) begin
         if (rem[0]) begin
            foreach (prod[r, c]) begin
               acc = 0;
               for (int k = 0; k < 6; k++)
                  acc = (acc + mulmod(power[r][k], step[k][c])) % 64'd1000000007;
               prod[r][c] = acc;
            end
            power = prod;
         end
         foreach (prod[r, c]) begin
            acc = 0;
            for (int k = 0; k < 6; k++)
               acc = (acc + mulmod(step[r][k], step[k][c])) % 64'd1000000007;
            prod[r][c] = acc;
         end
         step = prod;
         rem >>= 1;
      end
      acc = 0;
      for (int c = 0; c < 6; c++)
         acc = (acc + mulmod(power[0][c], 64'd1 << (5 - c))) % 64'd1000000007;
      return acc[dsc_pkg::RES_W-1:0];
   endfunction

   function void note_sum(bit [62:0] n);
      pending = {pending, count_rolls(64'(n))};
   endfunction

   function void check_count(bit [dsc_pkg::RES_W-1:0] got);
      bit [dsc_pkg::RES_W-1:0] want;
      if (pending.size() == 0) begin
         $error("way_count: unexpected word, actual %0d", got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         $error("way_count: expected %0d, actual %0d", want, got);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   rsp_seen = 0;
   way_count_board board = new();

   dsc_req_if #(.SUM_WIDTH(63)) req_ch();
   dsc_rsp_if rsp_ch();

   dice_sum_count_matrix_power #(.FACES(6), .SUM_WIDTH(63)) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #2 clock = ~clock;

   initial begin
      #100000000;
      $display("FAIL dice_sum_count_matrix_power");
      $finish;
   end

   function int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   task automatic send_sum(bit [62:0] n, bit idle);
      int gap;
      gap = idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.target_sum <= n;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_sum(n);
   endtask

   function bit [62:0] rand_sum(int bits);
      bit [62:0] v;
      v = 63'({$urandom, $urandom});
      return bits >= 63 ? v : v & ((63'd1 << bits) - 63'd1);
   endfunction

   // response side: random stalls plus one long hold-off
   initial begin
      int hold;
      int held_once;
      hold = 0;
      held_once = 0;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) rsp_seen++;
         if (hold > 0) hold--;
         else if (!held_once && rsp_seen == 30) begin
            hold = 20000;
            held_once = 1;
         end else if (rsp_seen > 60 && rsp_seen < 75) hold = 0;
         else if ($urandom_range(0, 3) == 0) hold = pick_gap();
         rsp_ch.ready <= (hold == 0);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_count(rsp_ch.way_count);

   initial begin
      bit [62:0] directed[$];
      int guard;
      req_ch.valid = 1'b0;
      req_ch.target_sum = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd6, 63'd7, 63'd8,
                   63'd12, 63'd13, 63'd100, 63'h7FFF_FFFF_FFFF_FFFF,
                   63'h4000_0000_0000_0000, 63'h2AAA_AAAA_AAAA_AAAA,
                   63'h5555_5555_5555_5555, 63'd1000000007};
      foreach (directed[i]) send_sum(directed[i], 1'b1);
      for (int i = 0; i < 100; i++) begin
         if (i >= 40 && i < 55)
            send_sum(rand_sum($urandom_range(1, 12)), 1'b0);
         else if ($urandom_range(0, 11) == 0)
            send_sum(rand_sum(63), 1'b1);
         else if ($urandom_range(0, 4) == 0)
            send_sum(63'($urandom_range(0, 8)), 1'b1);
         else
            send_sum(rand_sum($urandom_range(3, 18)), 1'b1);
      end
      req_ch.valid <= 1'b0;
      guard = 0;
      while (board.pending.size() > 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (board.pending.size() > 0) begin
         $error("way_count: %0d words never arrived", board.pending.size());
         board.errors++;
      end
      repeat (50) @(posedge clock);
      if (board.errors == 0)
         $display("PASS dice_sum_count_matrix_power");
      else
         $display("FAIL dice_sum_count_matrix_power");
      $finish;
   end
endmodule
